/* src/lisbs_pkg.sv */
// Shared types and constants for the LIS length search block.
`timescale 1ns / 1ps
package lisbs_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned LenW   = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAST,
    ST_SEARCH,
    ST_RESP
  } state_e;

endpackage

/* src/lisbs_in_if.sv */
// Input channel: one sequence element per beat.
`timescale 1ns / 1ps
interface lisbs_in_if
  import lisbs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic                     last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

/* src/lisbs_out_if.sv */
// Output channel: one running length result per beat.
`timescale 1ns / 1ps
interface lisbs_out_if
  import lisbs_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [LenW-1:0] length;
  logic            final_res;
  logic            overflow;

  modport source (output valid, length, final_res, overflow, input ready);
  modport sink   (input valid, length, final_res, overflow, output ready);
endinterface

/* src/lis_length_binary_search_top.sv */
// Longest strictly increasing subsequence length, patience table with binary search.
`timescale 1ns / 1ps
// Each input beat carries a signed 32-bit value and a last flag; each produces one result beat
// with the running LIS length, the last flag and a sticky overflow flag. The smallest tail for
// every length sits in a DEPTH-entry synchronous RAM. An item that opens a sequence goes from
// ST_IDLE straight to ST_RESP; one that extends the table, or meets a table that holds a single
// tail, passes ST_IDLE, ST_LAST and ST_RESP. Otherwise ST_LAST starts a binary search in
// ST_SEARCH of at most ceil(log2(count)) probes. One RAM read checks the last tail, then one
// RAM read serves each probe, since the single read port handles one probe per cycle. An output
// stall holds the result in ST_RESP until the output register is free. A new item is taken
// while the previous result still waits on the output register. Table contents need no
// clearing after reset: only written entries are read.
module lis_length_binary_search_top
  import lisbs_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lisbs_in_if.sink    in_i,
  lisbs_out_if.source out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  logic [CW-1:0]     count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [ValueW-1:0] key_q, key_d;
  logic              last_q, last_d;
  logic [AW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  logic              out_valid_q, out_valid_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              fin_q, fin_d;
  logic              res_ovf_q, res_ovf_d;

  logic [ValueW-1:0] tails_mem [DEPTH];
  logic [ValueW-1:0] tail_rd_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [ValueW-1:0] mem_wd;

  logic              accept, out_free, extend, full, single;
  logic [AW-1:0]     top_idx, lo_nx, hi_nx, mid_nx;
  logic [AW:0]       mid_sum;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign accept          = in_i.valid && in_i.ready;
  assign out_free        = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.length    = len_q;
  assign out_o.final_res = fin_q;
  assign out_o.overflow  = res_ovf_q;

  // Keys are stored with the sign bit flipped so unsigned order matches signed order.
  assign top_idx = AW'(count_q - CW'(1));
  assign extend  = key_q > tail_rd_q;
  assign full    = (count_q == CW'(DEPTH));
  assign single  = (count_q == CW'(1));

  // One probe: shrink the window around the first tail not below the key.
  always_comb begin
    lo_nx = lo_q;
    hi_nx = hi_q;
    if (tail_rd_q >= key_q) begin
      hi_nx = mid_q;
    end else begin
      lo_nx = mid_q + AW'(1);
    end
    mid_sum = {1'b0, lo_nx} + {1'b0, hi_nx};
    mid_nx  = mid_sum[AW:1];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (count_q == '0) ? ST_RESP : ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = (extend || single) ? ST_RESP : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!(lo_nx < hi_nx)) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    key_d       = key_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    len_d       = len_q;
    fin_d       = fin_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = key_q;
    mem_re      = 1'b0;
    mem_ra      = top_idx;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d  = {~in_i.value[ValueW-1], in_i.value[ValueW-2:0]};
          last_d = in_i.last;
          if (count_q == '0) begin
            // Open a sequence: the value becomes the first tail.
            mem_we  = 1'b1;
            mem_wa  = '0;
            mem_wd  = {~in_i.value[ValueW-1], in_i.value[ValueW-2:0]};
            count_d = CW'(1);
          end else begin
            mem_re = 1'b1;
            mem_ra = top_idx;
          end
        end
      end
      ST_LAST: begin
        if (extend) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            mem_we  = 1'b1;
            mem_wa  = AW'(count_q);
            count_d = count_q + CW'(1);
          end
        end else if (single) begin
          mem_we = 1'b1;
          mem_wa = '0;
        end else begin
          lo_d   = '0;
          hi_d   = top_idx;
          mid_d  = top_idx >> 1;
          mem_re = 1'b1;
          mem_ra = top_idx >> 1;
        end
      end
      ST_SEARCH: begin
        lo_d  = lo_nx;
        hi_d  = hi_nx;
        mid_d = mid_nx;
        if (lo_nx < hi_nx) begin
          mem_re = 1'b1;
          mem_ra = mid_nx;
        end else begin
          mem_we = 1'b1;
          mem_wa = lo_nx;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          len_d       = LenW'(count_q);
          fin_d       = last_q;
          res_ovf_d   = ovf_q;
          if (last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    last_q    <= last_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    len_q     <= len_d;
    fin_q     <= fin_d;
    res_ovf_q <= res_ovf_d;
  end

  // Tail table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tails_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      tail_rd_q <= tails_mem[mem_ra];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("tail count exceeds table depth");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flagged while table not full");

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("tail table read and written in one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input taken while an item is in flight");

endmodule
